// File: hw/rtl/rhpf_pkg.sv
// rhpf_pkg: shared types, hash constants and modular helpers for the pattern finder
package rhpf_pkg;

   localparam int HASH_W = 31;
   localparam logic [31:0] HASH_MOD = 32'd2000002853;
   localparam logic [7:0] HASH_BASE = 8'd137;

   localparam logic [1:0] OP_TEXT = 2'd0;
   localparam logic [1:0] OP_PATTERN = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PAT_MUL,
      ST_FIN,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FIN_WR,
      ST_Q_RD,
      ST_Q_CHK1,
      ST_Q_CHK2,
      ST_W_RD,
      ST_W_PUSH,
      ST_W_PWAIT,
      ST_W_TOP,
      ST_W_TWAIT,
      ST_R_RD1,
      ST_R_DROP,
      ST_R_DWAIT,
      ST_R_RD2,
      ST_R_PUSH,
      ST_R_PWAIT,
      ST_DONE
   } state_type;

   function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
      logic [31:0] sum;
      logic [31:0] red;
      begin
         sum = {1'b0, a} + {1'b0, b};
         red = (sum >= HASH_MOD) ? (sum - HASH_MOD) : sum;
         mod_add = red[HASH_W-1:0];
      end
   endfunction

   function automatic logic [HASH_W-1:0] mod_sub(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
      logic [31:0] dif;
      begin
         if (a >= b) begin
            dif = {1'b0, a} - {1'b0, b};
         end else begin
            dif = {1'b0, a} + HASH_MOD - {1'b0, b};
         end
         mod_sub = dif[HASH_W-1:0];
      end
   endfunction

endpackage

// File: hw/rtl/rolling_hash_pattern_finder_core.sv
// rolling_hash_pattern_finder_core: text and pattern store with rolling-hash query search
// text byte: stored as it is taken; pattern byte: one multiply, last byte then scans earlier slots
// query: hashes the first L text bytes, then rolls the window over the rest of the text, using
// the shared shift-add modular multiplier and the single text memory read port
// one item at a time; the result register frees the unit once a result is loaded
// synchronous reset clears text length, pattern count, open flag and the building pattern
module rolling_hash_pattern_finder_core #(
   parameter int TEXT_DEPTH    = 4096,
   parameter int PATTERN_SLOTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_symbol,
   input  logic       req_last,
   input  logic [5:0] req_query_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_answer_index,
   output logic       rsp_found
);

   localparam int HW     = rhpf_pkg::HASH_W;
   localparam int AW     = $clog2(TEXT_DEPTH);
   localparam int LEN_W  = $clog2(TEXT_DEPTH + 2);
   localparam int SLOT_W = $clog2(PATTERN_SLOTS);
   localparam int CNT_W  = $clog2(PATTERN_SLOTS + 1);
   localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(TEXT_DEPTH);
   localparam logic [LEN_W-1:0] SAT_LEN   = LEN_W'(TEXT_DEPTH + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(PATTERN_SLOTS);

   logic [7:0]      text_mem [TEXT_DEPTH];
   logic [HW-1:0]   hash_mem [PATTERN_SLOTS];
   logic [LEN_W-1:0] len_mem [PATTERN_SLOTS];
   logic [SLOT_W-1:0] alias_mem [PATTERN_SLOTS];

   rhpf_pkg::state_type state_ff, state_in;

   logic [LEN_W-1:0]  tlen_ff;
   logic              topen_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [HW-1:0]     bhash_ff;
   logic [LEN_W-1:0]  blen_ff;
   logic              blast_ff;
   logic [SLOT_W-1:0] alias_ff;
   logic [SLOT_W-1:0] scan_ff;
   logic [5:0]        q_ff;
   logic              found_ff;
   logic [LEN_W-1:0]  tgt_len_ff;
   logic [HW-1:0]     tgt_hash_ff;
   logic [HW-1:0]     h_ff;
   logic [HW-1:0]     top_ff;
   logic [LEN_W-1:0]  i_ff;
   logic              rsp_valid_ff;
   logic [5:0]        rsp_index_ff;
   logic              rsp_found_ff;

   logic [7:0]        text_q_ff;
   logic [HW-1:0]     hash_q_ff;
   logic [LEN_W-1:0]  len_q_ff;
   logic [SLOT_W-1:0] alias_q_ff;

   logic              accept;
   logic              txt_wr_en;
   logic [LEN_W-1:0]  eff_len;
   logic [AW-1:0]     text_rd_addr;
   logic [SLOT_W-1:0] pat_rd_addr;
   logic [CMP_W-1:0]  q_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic [CMP_W-1:0]  qff_ext;
   logic [LEN_W-1:0]  i_next;
   logic [LEN_W-1:0]  i_back;
   logic              rsp_free;

   logic              mul_start;
   logic [HW-1:0]     mul_a;
   logic [7:0]        mul_b;
   logic [HW-1:0]     mul_c;
   logic              mul_done;
   logic [HW-1:0]     mul_res;

   rhpf_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .c      (mul_c),
      .done   (mul_done),
      .result (mul_res)
   );

   assign accept   = req_valid && !req_stall;
   assign eff_len  = topen_ff ? tlen_ff : '0;
   assign q_ext    = CMP_W'(req_query_index);
   assign qff_ext  = CMP_W'(q_ff);
   assign cnt_ext  = CMP_W'(count_ff);
   assign i_next   = i_ff + LEN_W'(1);
   assign i_back   = i_ff - tgt_len_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rhpf_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  rhpf_pkg::OP_PATTERN: state_in = rhpf_pkg::ST_PAT_MUL;
                  rhpf_pkg::OP_QUERY: begin
                     if (q_ext < cnt_ext) begin
                        state_in = rhpf_pkg::ST_Q_RD;
                     end else begin
                        state_in = rhpf_pkg::ST_DONE;
                     end
                  end
                  default: state_in = rhpf_pkg::ST_IDLE;
               endcase
            end
         end
         rhpf_pkg::ST_PAT_MUL: begin
            if (mul_done) begin
               state_in = blast_ff ? rhpf_pkg::ST_FIN : rhpf_pkg::ST_IDLE;
            end
         end
         rhpf_pkg::ST_FIN: begin
            if (count_ff >= SLOTS_CNT) begin
               state_in = rhpf_pkg::ST_IDLE;
            end else if (blen_ff <= tlen_ff && count_ff != '0) begin
               state_in = rhpf_pkg::ST_SCAN_RD;
            end else begin
               state_in = rhpf_pkg::ST_FIN_WR;
            end
         end
         rhpf_pkg::ST_SCAN_RD: state_in = rhpf_pkg::ST_SCAN_CHK;
         rhpf_pkg::ST_SCAN_CHK: begin
            if ((len_q_ff <= tlen_ff && hash_q_ff == bhash_ff) ||
                (CNT_W'(scan_ff) + CNT_W'(1) == count_ff)) begin
               state_in = rhpf_pkg::ST_FIN_WR;
            end else begin
               state_in = rhpf_pkg::ST_SCAN_RD;
            end
         end
         rhpf_pkg::ST_FIN_WR: state_in = rhpf_pkg::ST_IDLE;
         rhpf_pkg::ST_Q_RD: state_in = rhpf_pkg::ST_Q_CHK1;
         rhpf_pkg::ST_Q_CHK1: begin
            state_in = (len_q_ff > tlen_ff) ? rhpf_pkg::ST_DONE : rhpf_pkg::ST_Q_CHK2;
         end
         rhpf_pkg::ST_Q_CHK2: begin
            if (len_q_ff == '0 || len_q_ff > tlen_ff) begin
               state_in = rhpf_pkg::ST_DONE;
            end else begin
               state_in = rhpf_pkg::ST_W_RD;
            end
         end
         rhpf_pkg::ST_W_RD: state_in = rhpf_pkg::ST_W_PUSH;
         rhpf_pkg::ST_W_PUSH: state_in = rhpf_pkg::ST_W_PWAIT;
         rhpf_pkg::ST_W_PWAIT: begin
            if (mul_done) begin
               if (i_next < tgt_len_ff) begin
                  state_in = rhpf_pkg::ST_W_TOP;
               end else if (mul_res == tgt_hash_ff || i_next >= tlen_ff) begin
                  state_in = rhpf_pkg::ST_DONE;
               end else begin
                  state_in = rhpf_pkg::ST_R_RD1;
               end
            end
         end
         rhpf_pkg::ST_W_TOP: state_in = rhpf_pkg::ST_W_TWAIT;
         rhpf_pkg::ST_W_TWAIT: begin
            if (mul_done) begin
               state_in = rhpf_pkg::ST_W_RD;
            end
         end
         rhpf_pkg::ST_R_RD1: state_in = rhpf_pkg::ST_R_DROP;
         rhpf_pkg::ST_R_DROP: state_in = rhpf_pkg::ST_R_DWAIT;
         rhpf_pkg::ST_R_DWAIT: begin
            if (mul_done) begin
               state_in = rhpf_pkg::ST_R_RD2;
            end
         end
         rhpf_pkg::ST_R_RD2: state_in = rhpf_pkg::ST_R_PUSH;
         rhpf_pkg::ST_R_PUSH: state_in = rhpf_pkg::ST_R_PWAIT;
         rhpf_pkg::ST_R_PWAIT: begin
            if (mul_done) begin
               if (mul_res == tgt_hash_ff || i_next >= tlen_ff) begin
                  state_in = rhpf_pkg::ST_DONE;
               end else begin
                  state_in = rhpf_pkg::ST_R_RD1;
               end
            end
         end
         rhpf_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = rhpf_pkg::ST_IDLE;
            end
         end
         default: state_in = rhpf_pkg::ST_IDLE;
      endcase
   end

   // unit operands, memory addresses and handshake
   always_comb begin
      req_stall    = (state_ff != rhpf_pkg::ST_IDLE);
      mul_start    = 1'b0;
      mul_a        = h_ff;
      mul_b        = rhpf_pkg::HASH_BASE;
      mul_c        = '0;
      text_rd_addr = i_ff[AW-1:0];
      pat_rd_addr  = scan_ff;
      txt_wr_en    = 1'b0;
      case (state_ff)
         rhpf_pkg::ST_IDLE: begin
            txt_wr_en = accept && req_operation == rhpf_pkg::OP_TEXT && eff_len < DEPTH_LEN;
            if (accept && req_operation == rhpf_pkg::OP_PATTERN) begin
               mul_start = 1'b1;
               mul_a     = bhash_ff;
               mul_c     = HW'(req_symbol);
            end
         end
         rhpf_pkg::ST_Q_RD: pat_rd_addr = qff_ext[SLOT_W-1:0];
         rhpf_pkg::ST_Q_CHK1: pat_rd_addr = alias_q_ff;
         rhpf_pkg::ST_W_PUSH: begin
            mul_start = 1'b1;
            mul_c     = HW'(text_q_ff);
         end
         rhpf_pkg::ST_W_TOP: begin
            mul_start = 1'b1;
            mul_a     = top_ff;
         end
         rhpf_pkg::ST_R_RD1: text_rd_addr = i_back[AW-1:0];
         rhpf_pkg::ST_R_DROP: begin
            mul_start = 1'b1;
            mul_a     = top_ff;
            mul_b     = text_q_ff;
         end
         rhpf_pkg::ST_R_PUSH: begin
            mul_start = 1'b1;
            mul_c     = HW'(text_q_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (txt_wr_en) begin
         text_mem[eff_len[AW-1:0]] <= req_symbol;
      end
      text_q_ff <= text_mem[text_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == rhpf_pkg::ST_FIN_WR) begin
         hash_mem[count_ff[SLOT_W-1:0]]  <= bhash_ff;
         len_mem[count_ff[SLOT_W-1:0]]   <= blen_ff;
         alias_mem[count_ff[SLOT_W-1:0]] <= alias_ff;
      end
      hash_q_ff  <= hash_mem[pat_rd_addr];
      len_q_ff   <= len_mem[pat_rd_addr];
      alias_q_ff <= alias_mem[pat_rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhpf_pkg::ST_IDLE;
         tlen_ff      <= '0;
         topen_ff     <= 1'b0;
         count_ff     <= '0;
         bhash_ff     <= '0;
         blen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == rhpf_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            rhpf_pkg::ST_IDLE: begin
               if (accept) begin
                  case (req_operation)
                     rhpf_pkg::OP_TEXT: begin
                        if (!topen_ff) begin
                           count_ff <= '0;
                           bhash_ff <= '0;
                           blen_ff  <= '0;
                        end
                        tlen_ff  <= (eff_len < DEPTH_LEN) ? eff_len + LEN_W'(1) : eff_len;
                        topen_ff <= !req_last;
                     end
                     rhpf_pkg::OP_PATTERN: begin
                        topen_ff <= 1'b0;
                        if (blen_ff < SAT_LEN) begin
                           blen_ff <= blen_ff + LEN_W'(1);
                        end
                     end
                     rhpf_pkg::OP_QUERY: topen_ff <= 1'b0;
                     default: begin
                     end
                  endcase
               end
            end
            rhpf_pkg::ST_PAT_MUL: begin
               if (mul_done) begin
                  bhash_ff <= mul_res;
               end
            end
            rhpf_pkg::ST_FIN: begin
               if (count_ff >= SLOTS_CNT) begin
                  bhash_ff <= '0;
                  blen_ff  <= '0;
               end
            end
            rhpf_pkg::ST_FIN_WR: begin
               count_ff <= count_ff + CNT_W'(1);
               bhash_ff <= '0;
               blen_ff  <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // payload and search registers
   always_ff @(posedge clock) begin
      case (state_ff)
         rhpf_pkg::ST_IDLE: begin
            blast_ff <= req_last;
            q_ff     <= req_query_index;
            found_ff <= 1'b0;
         end
         rhpf_pkg::ST_FIN: begin
            alias_ff <= count_ff[SLOT_W-1:0];
            scan_ff  <= '0;
         end
         rhpf_pkg::ST_SCAN_CHK: begin
            if (len_q_ff <= tlen_ff && hash_q_ff == bhash_ff) begin
               alias_ff <= alias_q_ff;
            end
            scan_ff <= scan_ff + SLOT_W'(1);
         end
         rhpf_pkg::ST_Q_CHK2: begin
            tgt_len_ff  <= len_q_ff;
            tgt_hash_ff <= hash_q_ff;
            h_ff        <= '0;
            top_ff      <= HW'(1);
            i_ff        <= '0;
         end
         rhpf_pkg::ST_W_PWAIT: begin
            if (mul_done) begin
               h_ff <= mul_res;
               i_ff <= i_next;
               if (i_next >= tgt_len_ff && mul_res == tgt_hash_ff) begin
                  found_ff <= 1'b1;
               end
            end
         end
         rhpf_pkg::ST_W_TWAIT: begin
            if (mul_done) begin
               top_ff <= mul_res;
            end
         end
         rhpf_pkg::ST_R_DWAIT: begin
            if (mul_done) begin
               h_ff <= rhpf_pkg::mod_sub(h_ff, mul_res);
            end
         end
         rhpf_pkg::ST_R_PWAIT: begin
            if (mul_done) begin
               h_ff <= mul_res;
               i_ff <= i_next;
               if (mul_res == tgt_hash_ff) begin
                  found_ff <= 1'b1;
               end
            end
         end
         rhpf_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_index_ff <= q_ff;
               rsp_found_ff <= found_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_answer_index = rsp_index_ff;
   assign rsp_found        = rsp_found_ff;

   // the multiplier only finishes while the sequencer waits on it
   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == rhpf_pkg::ST_PAT_MUL || state_ff == rhpf_pkg::ST_W_PWAIT ||
                    state_ff == rhpf_pkg::ST_W_TWAIT || state_ff == rhpf_pkg::ST_R_DWAIT ||
                    state_ff == rhpf_pkg::ST_R_PWAIT))
      else $error("multiplier finished outside a wait state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS_CNT)
      else $error("pattern count beyond slot count");

   a_text_bound: assert property (@(posedge clock) disable iff (reset)
      tlen_ff <= DEPTH_LEN)
      else $error("text length beyond text depth");

   a_hash_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rhpf_pkg::ST_R_RD1 || state_ff == rhpf_pkg::ST_W_RD) |->
         ({1'b0, h_ff} < rhpf_pkg::HASH_MOD))
      else $error("window hash not reduced");

   a_slot_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == rhpf_pkg::ST_FIN_WR |-> count_ff < SLOTS_CNT)
      else $error("pattern written with all slots used");

endmodule

// File: hw/rtl/rhpf_modmul.sv
// rhpf_modmul: shift-add modular multiply-accumulate, (a * b + c) mod the hash modulus
module rhpf_modmul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rhpf_pkg::HASH_W-1:0]    a,
   input  logic [7:0]                     b,
   input  logic [rhpf_pkg::HASH_W-1:0]    c,
   output logic                           done,
   output logic [rhpf_pkg::HASH_W-1:0]    result
);

   localparam logic [4:0] LAST_STEP = 5'd16;

   logic [rhpf_pkg::HASH_W-1:0] acc_ff;
   logic [rhpf_pkg::HASH_W-1:0] acc_in;
   logic [rhpf_pkg::HASH_W-1:0] a_ff;
   logic [rhpf_pkg::HASH_W-1:0] c_ff;
   logic [7:0]                  b_ff;
   logic [4:0]                  step_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [rhpf_pkg::HASH_W-1:0] addend;
   logic [2:0]                  bit_sel;

   // even steps double, odd steps add a when the bit is set, last step adds c
   always_comb begin
      bit_sel = 3'd7 - step_ff[3:1];
      if (step_ff == LAST_STEP) begin
         addend = c_ff;
      end else if (!step_ff[0]) begin
         addend = acc_ff;
      end else if (b_ff[bit_sel]) begin
         addend = a_ff;
      end else begin
         addend = '0;
      end
      acc_in = rhpf_pkg::mod_add(acc_ff, addend);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         a_ff    <= a;
         b_ff    <= b;
         c_ff    <= c;
         step_ff <= '0;
      end else if (busy_ff) begin
         acc_ff  <= acc_in;
         step_ff <= step_ff + 5'd1;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule
